// ----- src/mtg_pkg.sv -----
// Shared constants, types and the quarter-wave sine table of the test tone generator.
package mtg_pkg;

   localparam int MAX_CHANNELS     = 8;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int MODE_W      = 2;
   localparam int RATE_W      = 18;
   localparam int FREQ_W      = 15;
   localparam int AMP_W       = 15;
   localparam int GAIN_W      = 16;
   localparam int COUNT_W     = 4;
   localparam int CNTR_W      = 18;
   localparam int SAMPLE_W    = 16;
   localparam int SINE_W      = 16;
   localparam int OUT_CHAN_W  = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_USER_W  = 4;

   localparam int CHAN_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int K_W       = $clog2(MAX_CHANNELS + 1);
   localparam int FK_W      = FREQ_W + K_W;
   localparam int N_W       = CNTR_W + FK_W;
   localparam int PHASE_W   = 16;
   localparam int DVD_W     = N_W + PHASE_W;
   localparam int MCAND_W   = AMP_W + SINE_W;
   localparam int MPLIER_W  = CNTR_W;
   localparam int PROD_W    = MCAND_W + MPLIER_W;
   localparam int MAG_W     = AMP_W + SINE_W + GAIN_W;
   localparam int QUO_W     = MAG_W;
   localparam int DIVISOR_W = RATE_W;
   localparam int ROUND_SHIFT = 27;
   localparam int CONST_SHIFT = 15;
   localparam int RND_W       = MAG_W + 1 - ROUND_SHIFT;
   localparam int MUL_CNT_W   = $clog2(MPLIER_W);
   localparam int DIV_CNT_W   = $clog2(DVD_W);

   typedef enum logic [MODE_W-1:0] {
      WAVE_SINE   = 2'd0,
      WAVE_SAW    = 2'd1,
      WAVE_SQUARE = 2'd2,
      WAVE_CONST  = 2'd3
   } wave_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_WAVEFORM_MODE = 3'd0,
      REG_SAMPLE_RATE   = 3'd1,
      REG_TONE_FREQ     = 3'd2,
      REG_AMPLITUDE     = 3'd3,
      REG_GAIN          = 3'd4,
      REG_CHANNEL_COUNT = 3'd5,
      REG_RECORD_ENABLE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DVD_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef logic [SINE_W-1:0] sine_table_type [0:SINE_TABLE_DEPTH];

   // Q15 quarter sine, Taylor series in Q30, evaluated at elaboration
   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      logic [63:0]    sum;
      logic [63:0]    v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 156;
         sum  = sum + term;
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32768) begin
            v = 64'd32768;
         end
         tab[i] = v[SINE_W-1:0];
      end
      return tab;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

// ----- src/mtg_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module mtg_mul
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]    mc_ff, mc_in;
   logic [MPLIER_W-1:0]  mp_ff, mp_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         mc_in   = PROD_W'(req.mcand);
         mp_in   = req.mplier;
         cnt_in  = MUL_CNT_W'(MPLIER_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

// ----- src/mtg_div.sv -----
// Restoring divider, one quotient bit per cycle.
module mtg_div
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         dsr_in  = req.divisor;
         dvd_in  = req.dividend;
         quo_in  = '0;
         cnt_in  = DIV_CNT_W'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- src/multichannel_test_tone_generator_unit.sv -----
// Top level: register file, channel sequencer, phase counters and output register.
//
// A request on req_ carries a sample tick in req_tdata bit 0. With recording on and a
// nonzero channel count, the tick yields one response per active channel, channel 0
// first; rsp_tlast marks the final channel of the tick. A tick of 0, recording off or
// a channel count of 0 completes the request without any response.
// Registers are written through csr_wen/csr_addr/csr_wdata, one per cycle; the user
// must write them only while idle, as the block itself does not enforce it.
// Each channel runs through a bit-serial multiplier (18 steps) and a restoring
// divider (53 steps), shared by all channels:
//   sine, sawtooth:  count, divide, two multiplies
//   constant:        count, multiply, divide
//   square:          three multiplies
// A tick's channels run one after another, and a new request is taken once the last
// response of the previous one sits in the output register.
// The output register holds a response until rsp_tready; while it is full the
// sequencer holds the next channel's result and stalls.
// Reset (synchronous) restores the register defaults, clears all phase counters and
// empties the output register.
module multichannel_test_tone_generator_unit
   import mtg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_DATA_W-1:0]        req_tdata,   // [0] sample_tick
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic signed [SAMPLE_W-1:0]   rsp_tdata,   // [15:0] sample
   output logic [RSP_USER_W-1:0]        rsp_tuser,   // [2:0] channel, [3] clipped
   output logic                         rsp_tlast,
   input  logic                         csr_wen,
   input  logic [CSR_ADDR_W-1:0]        csr_addr,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LAUNCH = 9'b000000010,
      ST_MULN   = 9'b000000100,
      ST_UPD    = 9'b000001000,
      ST_DIV    = 9'b000010000,
      ST_LOOK   = 9'b000100000,
      ST_MULA   = 9'b001000000,
      ST_MULG   = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   // configuration
   wave_type             mode_ff;
   logic [RATE_W-1:0]    rate_ff;
   logic [FREQ_W-1:0]    freq_ff;
   logic [AMP_W-1:0]     amp_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rec_ff;

   logic [CNTR_W-1:0]    counter_ff [MAX_CHANNELS];
   logic                 cntr_we;
   logic [CNTR_W-1:0]    cntr_wdata;

   state_type            state_ff, state_in;
   logic [CHAN_W-1:0]    chan_ff, chan_in;
   logic [FK_W-1:0]      fk_ff, fk_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic [PHASE_W-1:0]   p_ff, p_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   mul_req_type          mul_req_ff, mul_req_in;
   div_req_type          div_req_ff, div_req_in;
   mul_rsp_type          mul_rsp;
   div_rsp_type          div_rsp;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic [OUT_CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic                 rsp_clip_ff, rsp_clip_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [K_W-1:0]       k;
   logic [K_W-1:0]       chans;
   logic                 last_chan;
   logic                 go;
   logic                 out_free;
   logic [CNTR_W-1:0]    cnt_cur;
   logic [N_W:0]         next_prod;
   logic                 sq_high;
   logic [SINE_AW+1:0]   idx;
   logic [SINE_AW:0]     tab_addr;
   logic [SINE_W-1:0]    x_val;
   logic                 x_neg;
   logic [MAG_W:0]       rnd_sum;
   logic [RND_W-1:0]     rounded;
   logic [SAMPLE_W-1:0]  sample_val;
   logic                 clip_val;

   mtg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req_ff),
      .rsp   (mul_rsp)
   );

   mtg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   // configuration writes; a zero gain is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= WAVE_SINE;
         rate_ff  <= RATE_W'(44100);
         freq_ff  <= FREQ_W'(440);
         amp_ff   <= AMP_W'(32000);
         gain_ff  <= GAIN_W'(4096);
         count_ff <= COUNT_W'(2);
         rec_ff   <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_WAVEFORM_MODE: mode_ff  <= wave_type'(csr_wdata[MODE_W-1:0]);
            REG_SAMPLE_RATE:   rate_ff  <= csr_wdata[RATE_W-1:0];
            REG_TONE_FREQ:     freq_ff  <= csr_wdata[FREQ_W-1:0];
            REG_AMPLITUDE:     amp_ff   <= csr_wdata[AMP_W-1:0];
            REG_GAIN: begin
               if (csr_wdata[GAIN_W-1:0] != '0) begin
                  gain_ff <= csr_wdata[GAIN_W-1:0];
               end
            end
            REG_CHANNEL_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            REG_RECORD_ENABLE: rec_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      k         = K_W'(chan_ff) + 1'b1;
      chans     = (5'(count_ff) > 5'(MAX_CHANNELS)) ? K_W'(MAX_CHANNELS) : K_W'(count_ff);
      last_chan = (k == chans);
      go        = req_tdata[0] && rec_ff && (chans != '0);
      out_free  = !rsp_valid_ff || rsp_tready;
      cnt_cur   = counter_ff[chan_ff];

      // counter returns to zero once the next count reaches one period, or when it is all ones
      next_prod  = (N_W + 1)'(n_ff) + (N_W + 1)'(fk_ff);
      cntr_wdata = ((cnt_cur == '1) || (next_prod >= (N_W + 1)'(rate_ff)))
                   ? '0 : cnt_cur + 1'b1;
      sq_high    = {n_ff, 1'b0} < (N_W + 1)'(rate_ff);

      // quarter-wave mirroring of the sine index
      idx = p_ff[PHASE_W-1 -: SINE_AW + 2];
      if (idx[SINE_AW]) begin
         tab_addr = (SINE_AW + 1)'(SINE_TABLE_DEPTH) - {1'b0, idx[SINE_AW-1:0]};
      end else begin
         tab_addr = {1'b0, idx[SINE_AW-1:0]};
      end

      unique case (mode_ff)
         WAVE_SINE: begin
            x_val = SINE_TABLE[tab_addr];
            x_neg = idx[SINE_AW+1];
         end
         WAVE_SAW: begin
            x_neg = !p_ff[PHASE_W-1];
            x_val = x_neg ? (SINE_W'(1 << (PHASE_W - 1)) - p_ff)
                          : (p_ff - SINE_W'(1 << (PHASE_W - 1)));
         end
         WAVE_SQUARE: begin
            x_val = sq_high ? SINE_W'(1 << (PHASE_W - 1)) : '0;
            x_neg = 1'b0;
         end
         default: begin
            x_val = '0;
            x_neg = 1'b0;
         end
      endcase

      // round half away from zero on the magnitude, then saturate
      rnd_sum = (MAG_W + 1)'(mag_ff) + (MAG_W + 1)'(1 << (ROUND_SHIFT - 1));
      rounded = rnd_sum[MAG_W:ROUND_SHIFT];
      if (neg_ff) begin
         clip_val   = rounded > RND_W'(32768);
         sample_val = clip_val ? SAMPLE_W'(16'h8000) : ('0 - rounded[SAMPLE_W-1:0]);
      end else begin
         clip_val   = rounded > RND_W'(32767);
         sample_val = clip_val ? SAMPLE_W'(16'h7FFF) : rounded[SAMPLE_W-1:0];
      end
   end

   // channel sequencer
   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      fk_in         = fk_ff;
      n_in          = n_ff;
      p_in          = p_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      mul_req_in    = mul_req_ff;
      div_req_in    = div_req_ff;
      mul_req_in.start = 1'b0;
      div_req_in.start = 1'b0;
      cntr_we       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_clip_in   = rsp_clip_ff;
      rsp_last_in   = rsp_last_ff;
      req_tready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && go) begin
               chan_in  = '0;
               fk_in    = FK_W'(freq_ff);
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            mul_req_in.start  = 1'b1;
            mul_req_in.mcand  = MCAND_W'(fk_ff);
            mul_req_in.mplier = MPLIER_W'(cnt_cur);
            state_in          = ST_MULN;
         end
         ST_MULN: begin
            if (mul_rsp.done) begin
               n_in     = mul_rsp.product[N_W-1:0];
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cntr_we = 1'b1;
            unique case (mode_ff)
               WAVE_CONST: begin
                  mul_req_in.start  = 1'b1;
                  mul_req_in.mcand  = MCAND_W'(amp_ff);
                  mul_req_in.mplier = MPLIER_W'(gain_ff);
                  state_in          = ST_MULA;
               end
               WAVE_SQUARE: begin
                  state_in = ST_LOOK;
               end
               default: begin
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = {n_ff, PHASE_W'(0)};
                  div_req_in.divisor  = rate_ff;
                  state_in            = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (mode_ff == WAVE_CONST) begin
                  mag_in   = div_rsp.quotient[MAG_W-1:0];
                  neg_in   = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  // zero rate: phase taken as zero
                  p_in     = (rate_ff == '0) ? '0 : div_rsp.quotient[PHASE_W-1:0];
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            neg_in            = x_neg;
            mul_req_in.start  = 1'b1;
            mul_req_in.mcand  = MCAND_W'(amp_ff);
            mul_req_in.mplier = MPLIER_W'(x_val);
            state_in          = ST_MULA;
         end
         ST_MULA: begin
            if (mul_rsp.done) begin
               if (mode_ff == WAVE_CONST) begin
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = DVD_W'(mul_rsp.product[AMP_W+GAIN_W-1:0])
                                        << CONST_SHIFT;
                  div_req_in.divisor  = DIVISOR_W'(k);
                  state_in            = ST_DIV;
               end else begin
                  mul_req_in.start  = 1'b1;
                  mul_req_in.mcand  = mul_rsp.product[MCAND_W-1:0];
                  mul_req_in.mplier = MPLIER_W'(gain_ff);
                  state_in          = ST_MULG;
               end
            end
         end
         ST_MULG: begin
            if (mul_rsp.done) begin
               mag_in   = mul_rsp.product[MAG_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_val;
               rsp_chan_in   = OUT_CHAN_W'(chan_ff);
               rsp_clip_in   = clip_val;
               rsp_last_in   = last_chan;
               if (last_chan) begin
                  state_in = ST_IDLE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  fk_in    = fk_ff + FK_W'(freq_ff);
                  state_in = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_req_ff   <= '0;
         div_req_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_req_ff   <= mul_req_in;
         div_req_ff   <= div_req_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff             <= chan_in;
      fk_ff               <= fk_in;
      n_ff                <= n_in;
      p_ff                <= p_in;
      mag_ff              <= mag_in;
      neg_ff              <= neg_in;
      rsp_sample_ff       <= rsp_sample_in;
      rsp_chan_ff         <= rsp_chan_in;
      rsp_clip_ff         <= rsp_clip_in;
      rsp_last_ff         <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            counter_ff[i] <= '0;
         end
      end else if (cntr_we) begin
         counter_ff[chan_ff] <= cntr_wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = {rsp_clip_ff, rsp_chan_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/mtg_checker.sv -----
// Port-level checks on the tone generator, bound to the top level.
module mtg_checker
   import mtg_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic signed [SAMPLE_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0]      rsp_tuser,
   input logic                       rsp_tlast
);

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // the block only goes busy by taking a request
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("ready dropped without a request");

   // a clipped sample sits at one of the rails
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |->
         (rsp_tdata == 16'sh7FFF) || (rsp_tdata == -16'sh8000))
      else $error("clip flag on an unsaturated sample");

endmodule

bind multichannel_test_tone_generator_unit mtg_checker u_mtg_checker (.*);

// ----- sim/tb_multichannel_test_tone_generator_unit.sv -----
// Self-checking testbench for the tone generator: directed corners, random configs.
module tb_multichannel_test_tone_generator_unit
   import mtg_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF     = 10;
   localparam int DRAIN_CYCLES = 1000;   // long enough for eight sine channels, plus margin
   localparam int PHASE_TICKS  = 60;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [OUT_CHAN_W-1:0]      channel;
      logic                       clipped;
      logic                       last;
   } tone_sample_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_W-1:0]      req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0]      rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0]      csr_addr   = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata  = '0;

   // tone model state
   wave_type           cfg_mode;
   logic [RATE_W-1:0]  cfg_rate;
   logic [FREQ_W-1:0]  cfg_freq;
   logic [AMP_W-1:0]   cfg_amp;
   logic [GAIN_W-1:0]  cfg_gain;
   logic [COUNT_W-1:0] cfg_count;
   logic               cfg_record;
   logic [CNTR_W-1:0]  phase_ctr [MAX_CHANNELS];
   bit [63:0]          quarter_sine [0:SINE_TABLE_DEPTH];

   tone_sample_type pending_samples [$];

   int unsigned req_gap_pct    = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned mismatch_count = 0;
   int unsigned samples_checked = 0;
   int unsigned clip_count     = 0;
   int unsigned ticks_sent     = 0;
   int unsigned config_sets    = 0;

   multichannel_test_tone_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [0] sample_tick
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] sample
      .rsp_tuser  (rsp_tuser),    // [2:0] channel, [3] clipped
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // Q15 quarter sine from a seven-term Taylor series in Q30
   function automatic void build_quarter_sine();
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      bit [63:0] sum;
      bit [63:0] v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / (2 * k * (2 * k + 1));
            if (k % 2) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32768) begin
            v = 64'd32768;
         end
         quarter_sine[i] = v;
      end
   endfunction

   function automatic void reset_tone_model();
      cfg_mode   = WAVE_SINE;
      cfg_rate   = 44100;
      cfg_freq   = 440;
      cfg_amp    = 32000;
      cfg_gain   = 4096;
      cfg_count  = 2;
      cfg_record = 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         phase_ctr[c] = '0;
      end
      build_quarter_sine();
   endfunction

   function automatic void apply_csr(input csr_index_type idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_WAVEFORM_MODE: cfg_mode   = wave_type'(val[MODE_W-1:0]);
         REG_SAMPLE_RATE:   cfg_rate   = val[RATE_W-1:0];
         REG_TONE_FREQ:     cfg_freq   = val[FREQ_W-1:0];
         REG_AMPLITUDE:     cfg_amp    = val[AMP_W-1:0];
         REG_GAIN: begin
            // a zero gain is dropped
            if (val[GAIN_W-1:0] != '0) begin
               cfg_gain = val[GAIN_W-1:0];
            end
         end
         REG_CHANNEL_COUNT: cfg_count  = val[COUNT_W-1:0];
         REG_RECORD_ENABLE: cfg_record = val[0];
         default: ;
      endcase
   endfunction

   // expected samples for one accepted request, advancing the phase counters
   function automatic void predict_tone_set(input logic tick);
      bit [63:0]    k;
      bit [63:0]    n;
      bit [63:0]    idx;
      bit [63:0]    quad;
      bit [63:0]    r;
      bit [63:0]    p;
      bit [63:0]    d;
      bit [63:0]    mag;
      bit [63:0]    rounded;
      bit [63:0]    nxt;
      int           chans;
      logic         neg;
      logic         clip;
      tone_sample_type s;
      if (!tick || !cfg_record) begin
         return;
      end
      chans = (cfg_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_count);
      for (int c = 0; c < chans; c++) begin
         k    = 64'(c + 1);
         n    = 64'(phase_ctr[c]) * 64'(cfg_freq) * k;
         neg  = 1'b0;
         clip = 1'b0;
         mag  = '0;
         case (cfg_mode)
            WAVE_SINE: begin
               idx = (cfg_rate != 0) ?
                     ((n * (4 * SINE_TABLE_DEPTH)) / 64'(cfg_rate)) % (4 * SINE_TABLE_DEPTH)
                     : 64'd0;
               quad = idx / SINE_TABLE_DEPTH;
               r    = idx % SINE_TABLE_DEPTH;
               if (quad[0]) begin
                  r = SINE_TABLE_DEPTH - r;
               end
               neg = (quad >= 2);
               mag = 64'(cfg_amp) * quarter_sine[r] * 64'(cfg_gain);
            end
            WAVE_SAW: begin
               p = (cfg_rate != 0) ? (((n << 16) / 64'(cfg_rate)) & 64'hFFFF) : 64'd0;
               if (p < 64'd32768) begin
                  neg = 1'b1;
                  d   = 64'd32768 - p;
               end else begin
                  d   = p - 64'd32768;
               end
               mag = 64'(cfg_amp) * d * 64'(cfg_gain);
            end
            WAVE_SQUARE: begin
               mag = (2 * n < 64'(cfg_rate)) ? ((64'(cfg_amp) << 15) * 64'(cfg_gain)) : 64'd0;
            end
            default: begin
               mag = ((64'(cfg_amp) * 64'(cfg_gain)) << 15) / k;
            end
         endcase
         rounded = (mag + (64'd1 << 26)) >> 27;
         if (neg) begin
            if (rounded > 64'd32768) begin
               rounded = 64'd32768;
               clip    = 1'b1;
            end
            s.sample = SAMPLE_W'(64'h10000 - rounded);
         end else begin
            if (rounded > 64'd32767) begin
               rounded = 64'd32767;
               clip    = 1'b1;
            end
            s.sample = SAMPLE_W'(rounded);
         end
         s.channel = OUT_CHAN_W'(c);
         s.clipped = clip;
         s.last    = (c + 1 == chans);
         pending_samples.push_back(s);

         nxt = (64'(phase_ctr[c]) + 1) & ((64'd1 << CNTR_W) - 1);
         if (nxt * 64'(cfg_freq) * k >= 64'(cfg_rate)) begin
            nxt = '0;
         end
         phase_ctr[c] = CNTR_W'(nxt);
      end
   endfunction

   function automatic void check_sample();
      tone_sample_type got;
      tone_sample_type want;
      got.sample  = rsp_tdata;
      got.channel = rsp_tuser[OUT_CHAN_W-1:0];
      got.clipped = rsp_tuser[OUT_CHAN_W];
      got.last    = rsp_tlast;
      samples_checked++;
      if (got.clipped === 1'b1) begin
         clip_count++;
      end
      if (pending_samples.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("unexpected sample: %0d ch %0d clip %0b last %0b",
                     got.sample, got.channel, got.clipped, got.last);
         end
      end else begin
         want = pending_samples.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display({"sample mismatch: expected %0d ch %0d clip %0b last %0b,",
                         " got %0d ch %0d clip %0b last %0b"},
                        want.sample, want.channel, want.clipped, want.last,
                        got.sample, got.channel, got.clipped, got.last);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_sample();
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_tick(input logic tick);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(tick);
      do @(posedge clock); while (!req_tready);
      ticks_sent++;
      predict_tone_set(tick);
   endtask

   // hold requests until every expected sample is back, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_csr(idx, val);
   endtask

   task automatic end_csr();
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      write_reg(idx, val);
      end_csr();
   endtask

   task automatic set_config(input wave_type mode, input int unsigned rate,
                             input int unsigned freq, input int unsigned amp,
                             input int unsigned gn, input int unsigned cnt,
                             input int unsigned rec);
      wait_idle();
      write_reg(REG_WAVEFORM_MODE, CSR_DATA_W'(mode));
      write_reg(REG_SAMPLE_RATE,   CSR_DATA_W'(rate));
      write_reg(REG_TONE_FREQ,     CSR_DATA_W'(freq));
      write_reg(REG_AMPLITUDE,     CSR_DATA_W'(amp));
      write_reg(REG_GAIN,          CSR_DATA_W'(gn));
      write_reg(REG_CHANNEL_COUNT, CSR_DATA_W'(cnt));
      write_reg(REG_RECORD_ENABLE, CSR_DATA_W'(rec));
      end_csr();
      config_sets++;
   endtask

   task automatic test_record_gating();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      // recording is off after reset
      send_tick(1'b1);
      send_tick(1'b0);
      program_reg(REG_RECORD_ENABLE, 1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
   endtask

   task automatic test_waveform_extremes();
      wave_type shape;
      shape = shape.first();
      repeat (4) begin
         // short period, full amplitude, max gain: heavy clipping on every shape
         set_config(shape, 12, 1, 32767, 65535, 8, 1);
         send_tick(1'b1);
         send_tick(1'b1);
         shape = shape.next();
      end
      set_config(WAVE_SAW, 192000, 20000, 0, 1, 3, 1);
      send_tick(1'b1);
      set_config(WAVE_SINE, 262143, 32767, 32767, 4096, 8, 1);
      send_tick(1'b1);
   endtask

   task automatic test_corner_cases();
      set_config(WAVE_SQUARE, 44100, 440, 20000, 4096, 2, 1);
      program_reg(REG_GAIN, 0);             // zero gain is dropped
      send_tick(1'b1);
      program_reg(REG_CHANNEL_COUNT, 0);    // no active channels
      send_tick(1'b1);
      program_reg(REG_CHANNEL_COUNT, 15);   // clamps to the channel limit
      send_tick(1'b1);
      program_reg(REG_SAMPLE_RATE, 0);
      send_tick(1'b1);
      send_tick(1'b1);
      set_config(WAVE_SAW, 48000, 0, 32767, 8192, 4, 1);
      send_tick(1'b1);
      // run counters up, then shrink the period under them
      set_config(WAVE_SINE, 192000, 1, 30000, 4096, 3, 1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      program_reg(REG_SAMPLE_RATE, 2);
      send_tick(1'b1);
   endtask

   task automatic randomize_config();
      wave_type    mode;
      int unsigned rate;
      int unsigned freq;
      int unsigned amp;
      int unsigned gn;
      int unsigned cnt;
      int unsigned rec;
      mode = wave_type'($urandom_range(3));
      case ($urandom_range(3))
         0:       rate = $urandom_range(1, 64);
         1:       rate = $urandom_range(1, 2000);
         2:       rate = $urandom_range(1, 192000);
         default: rate = $urandom_range(1) ? 262143 : 0;
      endcase
      case ($urandom_range(2))
         0:       freq = $urandom_range(1, 40);
         1:       freq = $urandom_range(1, 20000);
         default: freq = $urandom_range(1) ? 32767 : 0;
      endcase
      amp = ($urandom_range(3) == 0) ? 32767 : $urandom_range(0, 32767);
      case ($urandom_range(3))
         0:       gn = 4096;
         1:       gn = 65535;
         2:       gn = $urandom_range(1, 65535);
         default: gn = $urandom_range(0, 8191);
      endcase
      cnt = ($urandom_range(5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      rec = ($urandom_range(9) != 0);
      set_config(mode, rate, freq, amp, gn, cnt, rec);
   endtask

   task automatic test_random_phase(input int unsigned gap, input int unsigned stall);
      int unsigned done;
      int unsigned burst;
      logic        tick;
      req_gap_pct   = gap;
      rsp_stall_pct = stall;
      done          = 0;
      while (done < PHASE_TICKS) begin
         randomize_config();
         burst = $urandom_range(4, 16);
         repeat (burst) begin
            tick = ($urandom_range(9) != 0);
            send_tick(tick);
            if (tick && cfg_record && cfg_count != 0) begin
               done++;
            end
         end
         // pause mid-phase until all samples are back
         if ($urandom_range(3) == 0) begin
            wait_idle();
         end
      end
      wait_idle();
   endtask

   initial begin
      reset_tone_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_record_gating();
      test_waveform_extremes();
      test_corner_cases();
      test_random_phase(0, 0);
      test_random_phase(73, 0);
      test_random_phase(0, 73);
      test_random_phase(6, 6);
      wait_idle();
      $display("ran %0d ticks over %0d configurations, all four waveforms",
               ticks_sent, config_sets);
      $display("checked %0d samples, %0d clipped, %0d mismatches",
               samples_checked, clip_count, mismatch_count);
      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("tb_multichannel_test_tone_generator_unit: clean");
      end else begin
         $display("tb_multichannel_test_tone_generator_unit: errors");
      end
      $finish;
   end

   initial begin
      #(100_000_000);
      $display("timeout with %0d samples outstanding", pending_samples.size());
      $display("tb_multichannel_test_tone_generator_unit: errors");
      $finish;
   end

endmodule

// ----- files.f -----
src/mtg_pkg.sv
src/mtg_mul.sv
src/mtg_div.sv
src/multichannel_test_tone_generator_unit.sv
src/mtg_checker.sv
sim/tb_multichannel_test_tone_generator_unit.sv
